// ----- rtl/scg_pkg.sv -----
// shared constants, types and the quarter-wave cosine table of the cosine generator
package scg_pkg;

    // phase and table geometry
    localparam int PHASE_BITS      = 32;
    localparam int TABLE_ADDR_BITS = 8;
    localparam int TABLE_WIDTH     = 16;
    localparam int TABLE_SIZE      = 1 << TABLE_ADDR_BITS;

    // register and field widths
    localparam int REG_PHASE_W = 32;
    localparam int AMP_W       = 16;
    localparam int VAL_W       = 24;
    localparam int IDX_W       = 16;
    localparam int FRAC_BITS   = 8;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    // quadrant plus table address taken from the top of the phase
    localparam int ANGLE_W = TABLE_ADDR_BITS + 2;
    localparam int PROD_W  = TABLE_WIDTH + AMP_W;
    localparam int MAG_W   = PROD_W + 1 - (TABLE_WIDTH - 1);
    localparam int SUM_W   = ((MAG_W > VAL_W) ? MAG_W : VAL_W) + 2;
    localparam int RND_W   = VAL_W + 2;

    // saturation limits, signed Q16.8
    localparam int SAT_MAX   = (1 << (VAL_W - 1)) - 1;
    localparam int SAT_MIN   = -(1 << (VAL_W - 1));
    localparam int WHOLE_MAX = (1 << (VAL_W - 1)) - (1 << FRAC_BITS);
    localparam int FRAC_HALF = 1 << (FRAC_BITS - 1);
    localparam int PROD_HALF = 1 << (TABLE_WIDTH - 2);

    // queues, depths are powers of two
    localparam int CMD_DEPTH   = 2;
    localparam int CMD_PTR_W   = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W   = $clog2(CMD_DEPTH + 1);
    localparam int OUT_DEPTH   = 8;
    localparam int OUT_PTR_W   = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W   = $clog2(OUT_DEPTH + 1);

    // register reset values
    localparam logic [REG_PHASE_W-1:0] PHASE_STEP_RESET  = 32'd85899346;
    localparam logic [REG_PHASE_W-1:0] START_PHASE_RESET = '0;
    localparam logic [AMP_W-1:0]       AMPLITUDE_RESET   = 16'd256;
    localparam logic [VAL_W-1:0]       DC_OFFSET_RESET   = '0;
    localparam logic [IDX_W-1:0]       SAMPLE_COUNT_RESET = 16'd101;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PHASE_STEP   = 3'd0,
        REG_START_PHASE  = 3'd1,
        REG_AMPLITUDE    = 3'd2,
        REG_DC_OFFSET    = 3'd3,
        REG_SAMPLE_COUNT = 3'd4,
        REG_ROUND_MODE   = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [REG_PHASE_W-1:0]  phase_step;
        logic [REG_PHASE_W-1:0]  start_phase;
        logic [AMP_W-1:0]        amplitude;
        logic signed [VAL_W-1:0] dc_offset;
        logic [IDX_W-1:0]        sample_count;
        logic                    round_mode;
    } cfg_t;

    // one classified sample tick handed from front to back
    typedef struct packed {
        logic [ANGLE_W-1:0] angle;
        logic [IDX_W-1:0]   index;
        logic               last;
    } cmd_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [IDX_W-1:0]        index;
        logic                    last;
    } res_t;

    typedef logic [TABLE_SIZE-1:0][TABLE_WIDTH-1:0] cos_table_t;

    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam int          TAB_SHIFT   = 31 - TABLE_WIDTH;
    localparam logic [63:0] TAB_HALF    = 64'd1 << (TAB_SHIFT - 1);

    // taylor term divisor 2n(2n-1)
    function automatic logic [63:0] taylor_div(logic [63:0] p, int n);
        logic [63:0] q;
        unique case (n)
            11:      q = p / 64'd462;
            10:      q = p / 64'd380;
            9:       q = p / 64'd306;
            8:       q = p / 64'd240;
            7:       q = p / 64'd182;
            6:       q = p / 64'd132;
            5:       q = p / 64'd90;
            4:       q = p / 64'd56;
            3:       q = p / 64'd30;
            2:       q = p / 64'd12;
            default: q = p / 64'd2;
        endcase
        return q;
    endfunction

    // cos(k/size * pi/2) in unsigned Q1.(TABLE_WIDTH-1), horner form in Q30
    function automatic logic [TABLE_WIDTH-1:0] cos_entry(int k);
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] r;
        x = (HALF_PI_Q30 * 64'(k)) >> TABLE_ADDR_BITS;
        y = (x * x) >> 30;
        t = Q30_ONE;
        for (int n = 11; n >= 1; n--) begin
            s = taylor_div((y * t) >> 30, n);
            t = (s > Q30_ONE) ? 64'd0 : Q30_ONE - s;
        end
        r = (t + TAB_HALF) >> TAB_SHIFT;
        return r[TABLE_WIDTH-1:0];
    endfunction

    function automatic cos_table_t build_cos_table();
        cos_table_t tbl;
        for (int k = 0; k < TABLE_SIZE; k++) begin
            tbl[k] = cos_entry(k);
        end
        return tbl;
    endfunction

    localparam cos_table_t COS_TABLE = build_cos_table();

    // 32-bit register phase placed onto the accumulator width
    function automatic logic [PHASE_BITS-1:0] align_phase(logic [REG_PHASE_W-1:0] v);
        logic [PHASE_BITS+REG_PHASE_W-1:0] w;
        w = {v, {PHASE_BITS{1'b0}}};
        return w[PHASE_BITS+REG_PHASE_W-1 -: PHASE_BITS];
    endfunction

endpackage

// ----- rtl/scg_front.sv -----
// front end: takes sample ticks, runs the phase accumulator and the sample counter
module scg_front (
    input  logic          clk,
    input  logic          rst_n,
    input  scg_pkg::cfg_t cfg,
    input  logic          push,
    input  logic          restart,
    input  logic          q_full,
    output logic          cmd_wr,
    output scg_pkg::cmd_t cmd
);

    logic [scg_pkg::PHASE_BITS-1:0] phase_reg;
    logic [scg_pkg::PHASE_BITS-1:0] phase_next;
    logic [scg_pkg::IDX_W-1:0]      idx_reg;
    logic [scg_pkg::IDX_W-1:0]      idx_next;
    logic [scg_pkg::PHASE_BITS-1:0] cur_phase;
    logic [scg_pkg::IDX_W-1:0]      cur_idx;
    logic [scg_pkg::IDX_W-1:0]      last_idx;
    logic                           is_last;

    assign cmd_wr    = push && !q_full;
    assign cur_phase = restart ? scg_pkg::align_phase(cfg.start_phase) : phase_reg;
    assign cur_idx   = restart ? '0 : idx_reg;
    assign last_idx  = cfg.sample_count - scg_pkg::IDX_W'(1);
    assign is_last   = (cur_idx == last_idx);

    assign cmd.angle = cur_phase[scg_pkg::PHASE_BITS-1 -: scg_pkg::ANGLE_W];
    assign cmd.index = cur_idx;
    assign cmd.last  = is_last;

    always_comb
    begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        if (cmd_wr)
        begin
            if (is_last)
            begin
                phase_next = scg_pkg::align_phase(cfg.start_phase);
                idx_next   = '0;
            end
            else
            begin
                phase_next = cur_phase + scg_pkg::align_phase(cfg.phase_step);
                idx_next   = cur_idx + scg_pkg::IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= scg_pkg::align_phase(scg_pkg::START_PHASE_RESET);
            idx_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
        end
    end

    // a flagged last sample always starts the next run at index zero
    a_run_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_wr && is_last) |=> (idx_reg == '0))
        else $error("index did not return to zero after last sample");

endmodule

// ----- rtl/scg_cmd_queue.sv -----
// short queue of classified ticks between front end and back end
module scg_cmd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr,
    input  scg_pkg::cmd_t wr_data,
    output logic          full,
    input  logic          rd,
    output logic          rd_valid,
    output scg_pkg::cmd_t rd_data
);

    scg_pkg::cmd_t                  mem [scg_pkg::CMD_DEPTH];
    logic [scg_pkg::CMD_PTR_W-1:0]  wr_ptr_reg;
    logic [scg_pkg::CMD_PTR_W-1:0]  rd_ptr_reg;
    logic [scg_pkg::CMD_CNT_W-1:0]  cnt_reg;
    logic [scg_pkg::CMD_CNT_W-1:0]  cnt_next;

    assign full     = (cnt_reg == scg_pkg::CMD_CNT_W'(scg_pkg::CMD_DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (wr && !rd)
        begin
            cnt_next = cnt_reg + scg_pkg::CMD_CNT_W'(1);
        end
        else if (rd && !wr)
        begin
            cnt_next = cnt_reg - scg_pkg::CMD_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + scg_pkg::CMD_PTR_W'(1);
            end
            if (rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + scg_pkg::CMD_PTR_W'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        wr |-> (!full || rd))
        else $error("command queue written while full");

    a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
        rd |-> rd_valid)
        else $error("command queue read while empty");

endmodule

// ----- rtl/scg_back.sv -----
// back end: table lookup, amplitude multiply, offset, saturation, rounding, result queue
module scg_back (
    input  logic          clk,
    input  logic          rst_n,
    input  scg_pkg::cfg_t cfg,
    input  logic          cmd_valid,
    input  scg_pkg::cmd_t cmd,
    output logic          cmd_rd,
    output logic          empty,
    input  logic          pop,
    output scg_pkg::res_t res
);

    // issue / lookup
    logic [1:0]                           quad;
    logic [scg_pkg::TABLE_ADDR_BITS-1:0]  taddr;
    logic [scg_pkg::TABLE_ADDR_BITS-1:0]  raddr;
    logic                                 mirror;
    logic [scg_pkg::TABLE_WIDTH-1:0]      mag;
    logic [scg_pkg::OUT_CNT_W:0]          credit_used;

    // stage 1: magnitude from table
    logic                                 s1_v_reg;
    logic [scg_pkg::TABLE_WIDTH-1:0]      s1_mag_reg;
    logic                                 s1_neg_reg;
    logic [scg_pkg::IDX_W-1:0]            s1_index_reg;
    logic                                 s1_last_reg;

    // stage 2: product
    logic                                 s2_v_reg;
    logic [scg_pkg::PROD_W-1:0]           s2_prod_reg;
    logic                                 s2_neg_reg;
    logic [scg_pkg::IDX_W-1:0]            s2_index_reg;
    logic                                 s2_last_reg;

    // stage 3: saturated sample
    logic [scg_pkg::PROD_W:0]             prod_rnd;
    logic [scg_pkg::MAG_W-1:0]            mag_rnd;
    logic signed [scg_pkg::SUM_W-1:0]     mag_s;
    logic signed [scg_pkg::SUM_W-1:0]     sum;
    logic signed [scg_pkg::VAL_W-1:0]     sat_val;
    logic                                 s3_v_reg;
    logic signed [scg_pkg::VAL_W-1:0]     s3_val_reg;
    logic [scg_pkg::IDX_W-1:0]            s3_index_reg;
    logic                                 s3_last_reg;

    // whole-number rounding on the way into the queue
    logic signed [scg_pkg::RND_W-1:0]     v_ext;
    logic signed [scg_pkg::RND_W-1:0]     v_rnd;
    scg_pkg::res_t                        wr_res;

    // result queue
    scg_pkg::res_t                        fifo_mem [scg_pkg::OUT_DEPTH];
    logic [scg_pkg::OUT_PTR_W-1:0]        wr_ptr_reg;
    logic [scg_pkg::OUT_PTR_W-1:0]        rd_ptr_reg;
    logic [scg_pkg::OUT_CNT_W-1:0]        cnt_reg;
    logic [scg_pkg::OUT_CNT_W-1:0]        cnt_next;
    logic                                 pop_fire;

    // a tick issues only when its result is sure to find a queue slot
    assign credit_used = {1'b0, cnt_reg}
                       + (scg_pkg::OUT_CNT_W+1)'(s1_v_reg)
                       + (scg_pkg::OUT_CNT_W+1)'(s2_v_reg)
                       + (scg_pkg::OUT_CNT_W+1)'(s3_v_reg);
    assign cmd_rd = cmd_valid
                 && (credit_used < (scg_pkg::OUT_CNT_W+1)'(scg_pkg::OUT_DEPTH));

    // quadrants 1 and 3 read the mirrored address, zero at the quadrant edge
    assign quad   = cmd.angle[scg_pkg::ANGLE_W-1 -: 2];
    assign taddr  = cmd.angle[scg_pkg::TABLE_ADDR_BITS-1:0];
    assign mirror = quad[0];
    assign raddr  = mirror ? (-taddr) : taddr;
    assign mag    = (mirror && (taddr == '0)) ? '0 : scg_pkg::COS_TABLE[raddr];

    always_comb
    begin
        prod_rnd = {1'b0, s2_prod_reg} + (scg_pkg::PROD_W+1)'(scg_pkg::PROD_HALF);
        mag_rnd  = prod_rnd[scg_pkg::PROD_W -: scg_pkg::MAG_W];
        mag_s    = signed'(scg_pkg::SUM_W'(mag_rnd));
        sum      = (s2_neg_reg ? -mag_s : mag_s) + scg_pkg::SUM_W'(cfg.dc_offset);
        if (sum > scg_pkg::SUM_W'(scg_pkg::SAT_MAX))
        begin
            sat_val = scg_pkg::VAL_W'(scg_pkg::SAT_MAX);
        end
        else if (sum < scg_pkg::SUM_W'(scg_pkg::SAT_MIN))
        begin
            sat_val = scg_pkg::VAL_W'(scg_pkg::SAT_MIN);
        end
        else
        begin
            sat_val = sum[scg_pkg::VAL_W-1:0];
        end
    end

    always_comb
    begin
        v_ext = scg_pkg::RND_W'(s3_val_reg);
        v_rnd = v_ext;
        if (cfg.round_mode)
        begin
            if (!s3_val_reg[scg_pkg::VAL_W-1])
            begin
                v_rnd = v_ext + scg_pkg::RND_W'(scg_pkg::FRAC_HALF);
                v_rnd[scg_pkg::FRAC_BITS-1:0] = '0;
                if (v_rnd > scg_pkg::RND_W'(scg_pkg::WHOLE_MAX))
                begin
                    v_rnd = scg_pkg::RND_W'(scg_pkg::WHOLE_MAX);
                end
            end
            else
            begin
                v_rnd = -v_ext + scg_pkg::RND_W'(scg_pkg::FRAC_HALF);
                v_rnd[scg_pkg::FRAC_BITS-1:0] = '0;
                v_rnd = -v_rnd;
            end
        end
        wr_res.value = v_rnd[scg_pkg::VAL_W-1:0];
        wr_res.index = s3_index_reg;
        wr_res.last  = s3_last_reg;
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        s1_mag_reg   <= mag;
        s1_neg_reg   <= quad[1] ^ quad[0];
        s1_index_reg <= cmd.index;
        s1_last_reg  <= cmd.last;
        s2_prod_reg  <= scg_pkg::PROD_W'(s1_mag_reg) * scg_pkg::PROD_W'(cfg.amplitude);
        s2_neg_reg   <= s1_neg_reg;
        s2_index_reg <= s1_index_reg;
        s2_last_reg  <= s1_last_reg;
        s3_val_reg   <= sat_val;
        s3_index_reg <= s2_index_reg;
        s3_last_reg  <= s2_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= cmd_rd;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
        end
    end

    // result queue
    assign empty    = (cnt_reg == '0);
    assign pop_fire = pop && !empty;
    assign res      = fifo_mem[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (s3_v_reg && !pop_fire)
        begin
            cnt_next = cnt_reg + scg_pkg::OUT_CNT_W'(1);
        end
        else if (pop_fire && !s3_v_reg)
        begin
            cnt_next = cnt_reg - scg_pkg::OUT_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_v_reg)
        begin
            fifo_mem[wr_ptr_reg] <= wr_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (s3_v_reg)
            begin
                wr_ptr_reg <= wr_ptr_reg + scg_pkg::OUT_PTR_W'(1);
            end
            if (pop_fire)
            begin
                rd_ptr_reg <= rd_ptr_reg + scg_pkg::OUT_PTR_W'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

    // queued plus in-flight results never exceed the queue
    a_credit: assert property (@(posedge clk) disable iff (!rst_n)
        credit_used <= (scg_pkg::OUT_CNT_W+1)'(scg_pkg::OUT_DEPTH))
        else $error("result queue credit overrun");

    a_pipe_moves: assert property (@(posedge clk) disable iff (!rst_n)
        s1_v_reg |=> (s2_v_reg && s3_v_reg == $past(s2_v_reg)))
        else $error("back-end pipeline lost a sample");

endmodule

// ----- rtl/sampled_cosine_generator.sv -----
// top level of the sampled cosine generator: register file, front end, queue, back end
//
// Numerically controlled cosine oscillator. Every transfer on the input queue
// interface (push while full is low) is one sample tick and yields exactly one
// result transfer: sample_value = amplitude * cos(2*pi*phase) + dc_offset,
// saturated signed Q16.8, optionally rounded half away from zero to a whole
// number; sample_index is its position in the run and last_sample marks the
// final sample of a run of sample_count samples (a count of 0 means 65536).
// After the last sample the index goes back to zero and the phase reloads
// from start_phase; restart on a tick does the same before that tick's
// sample. The phase accumulator adds phase_step per sample and wraps.
// Rate: one sample per clock sustained while the consumer keeps popping, a
// new tick may be pushed every cycle while full is low. A tick's result becomes
// visible (empty low) after the command queue, table lookup, amplitude multiply
// and offset/saturation stages; whole-number rounding is applied as the result
// enters the 8-entry result queue. The back end only issues a tick when the
// result queue has room for it, so full rises only after the consumer has
// stopped popping long enough to fill both queues. The configuration port is
// always ready; write registers only while no tick is in flight. start_phase
// takes effect at the next restart or run end, the others on the next tick.
module sampled_cosine_generator (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration writes
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [scg_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [scg_pkg::CFG_DATA_W-1:0]        cfg_data,
    // sample ticks
    input  logic                                  push,
    output logic                                  full,
    input  logic                                  restart,
    // generated samples
    output logic                                  empty,
    input  logic                                  pop,
    output logic signed [scg_pkg::VAL_W-1:0]      sample_value,
    output logic [scg_pkg::IDX_W-1:0]             sample_index,
    output logic                                  last_sample
);

    scg_pkg::cfg_t cfg_reg;
    scg_pkg::cfg_t cfg_next;
    scg_pkg::cmd_t front_cmd;
    scg_pkg::cmd_t head_cmd;
    scg_pkg::res_t res;
    logic          cmd_wr;
    logic          cmd_rd;
    logic          cmd_valid;
    logic          q_full;

    // register file, every write transfer to a defined register index lands in the same cycle
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (scg_pkg::cfg_reg_t'(cfg_index))
                scg_pkg::REG_PHASE_STEP:
                    cfg_next.phase_step = cfg_data[scg_pkg::REG_PHASE_W-1:0];
                scg_pkg::REG_START_PHASE:
                    cfg_next.start_phase = cfg_data[scg_pkg::REG_PHASE_W-1:0];
                scg_pkg::REG_AMPLITUDE:
                    cfg_next.amplitude = cfg_data[scg_pkg::AMP_W-1:0];
                scg_pkg::REG_DC_OFFSET:
                    cfg_next.dc_offset = signed'(cfg_data[scg_pkg::VAL_W-1:0]);
                scg_pkg::REG_SAMPLE_COUNT:
                    cfg_next.sample_count = cfg_data[scg_pkg::IDX_W-1:0];
                scg_pkg::REG_ROUND_MODE:
                    cfg_next.round_mode = cfg_data[0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.phase_step   <= scg_pkg::PHASE_STEP_RESET;
            cfg_reg.start_phase  <= scg_pkg::START_PHASE_RESET;
            cfg_reg.amplitude    <= scg_pkg::AMPLITUDE_RESET;
            cfg_reg.dc_offset    <= signed'(scg_pkg::DC_OFFSET_RESET);
            cfg_reg.sample_count <= scg_pkg::SAMPLE_COUNT_RESET;
            cfg_reg.round_mode   <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front end owns phase and index, one tick per cycle while full is low
    scg_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .push    (push),
        .restart (restart),
        .q_full  (q_full),
        .cmd_wr  (cmd_wr),
        .cmd     (front_cmd)
    );

    assign full = q_full;

    // decouples the front end from back-end stalls
    scg_cmd_queue u_cmd_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (cmd_wr),
        .wr_data  (front_cmd),
        .full     (q_full),
        .rd       (cmd_rd),
        .rd_valid (cmd_valid),
        .rd_data  (head_cmd)
    );

    // arithmetic pipeline and result queue
    scg_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (cmd_valid),
        .cmd       (head_cmd),
        .cmd_rd    (cmd_rd),
        .empty     (empty),
        .pop       (pop),
        .res       (res)
    );

    assign sample_value = res.value;
    assign sample_index = res.index;
    assign last_sample  = res.last;

endmodule
